>>> sv/decimal_number_glyph_renderer_macros.svh
// Assertion macros for the decimal number glyph renderer.
`ifndef DECIMAL_NUMBER_GLYPH_RENDERER_MACROS_SVH
`define DECIMAL_NUMBER_GLYPH_RENDERER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset
`define DNGR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dngr check failed");

// Next-cycle implication, clocked on clk, off while in reset
`define DNGR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dngr check failed");

`endif

>>> sv/dngr_pkg.sv
// Types, constants, glyph tables and helpers for the glyph renderer.
`default_nettype none

package dngr_pkg;

	localparam int ROW_PITCH_DEF  = 128;
	localparam int VALUE_BITS_DEF = 16;
	localparam int VALUE_W        = 16;
	localparam int ADDR_W         = 14;
	localparam int PIX_W          = 10;
	localparam int COLS           = 5;

	localparam logic [2:0] LAST_ROW = 3'd6;

	// Input item and result item
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [6:0]         x_pos;
		logic [6:0]         y_pos;
		logic [7:0]         colour;
	} dngr_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] row_address;
		logic [PIX_W-1:0]  pixel_a;
		logic [PIX_W-1:0]  pixel_b;
		logic [PIX_W-1:0]  pixel_c;
		logic [PIX_W-1:0]  pixel_d;
		logic [PIX_W-1:0]  pixel_e;
		logic [COLS-1:0]   write_mask;
		logic              last_row;
	} dngr_out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       pad_glyph;
		logic       extract;
		logic       emit;
		logic       glyph_end;
		logic       last;
		logic [2:0] row;
	} dngr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic done;
	} dngr_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_ROWS
	} dngr_state_t;

	// One hex nibble per column, column 0 leftmost; shade in the low two bits
	localparam logic [19:0] GLYPH_ROM [10][7] = '{
		'{20'h03320, 20'h30030, 20'h30031, 20'h30031, 20'h30031, 20'h32230, 20'h03310},
		'{20'h00220, 20'h01320, 20'h12220, 20'h00220, 20'h00220, 20'h00220, 20'h00220},
		'{20'h01321, 20'h13112, 20'h00012, 20'h00131, 20'h01320, 20'h02200, 20'h13332},
		'{20'h03300, 20'h32230, 20'h00230, 20'h03320, 20'h00230, 20'h31230, 20'h03300},
		'{20'h00030, 20'h00231, 20'h00331, 20'h02231, 20'h03031, 20'h23333, 20'h00030},
		'{20'h03330, 20'h23000, 20'h23320, 20'h00131, 20'h00032, 20'h32031, 20'h03320},
		'{20'h02320, 20'h13030, 20'h23000, 20'h23330, 20'h23032, 20'h13032, 20'h02330},
		'{20'h23332, 20'h00031, 20'h00130, 20'h00320, 20'h01300, 20'h02300, 20'h02300},
		'{20'h02330, 20'h13023, 20'h13023, 20'h02330, 20'h13023, 20'h13023, 20'h02330},
		'{20'h03300, 20'h30230, 20'h30230, 20'h03330, 20'h00130, 20'h31230, 20'h03300}
	};

	// Digits 1, 3 and 9 are four pixels wide
	localparam logic [9:0] GLYPH_NARROW = 10'b10_0000_1010;

	function automatic logic is_narrow(input logic [3:0] digit);
		return GLYPH_NARROW[digit];
	endfunction

	function automatic logic [1:0] glyph_shade(input logic [3:0] digit,
		input logic [2:0] row, input int col);
		logic [19:0] bits;
		bits = GLYPH_ROM[digit][row];
		return bits[16-4*col +: 2];
	endfunction

	// Shade times colour without a multiplier
	function automatic logic [PIX_W-1:0] shade_pixel(input logic [1:0] shade,
		input logic [7:0] colour);
		logic [PIX_W-1:0] c;
		logic [PIX_W-1:0] res;
		c = PIX_W'(colour);
		unique case (shade)
			2'd0: res = '0;
			2'd1: res = c;
			2'd2: res = c << 1;
			2'd3: res = (c << 1) + c;
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

>>> sv/decimal_number_glyph_renderer.sv
// Each glyph is one digit step (divide by ten, or a zero pad) followed by 7 row writes.
// An item of n digits draws n glyphs, plus two zero pad glyphs when padding is enabled.
// The first row item goes through the digit and rows states into the result register; output stalls delay it.
// The next item is accepted once the last row is in the result register.
// Reset (arst_n low, asynchronous) idles the controller, drops rsp_valid, clears pad.
`default_nettype none

`include "decimal_number_glyph_renderer_macros.svh"

module decimal_number_glyph_renderer #(
	parameter int ROW_PITCH  = dngr_pkg::ROW_PITCH_DEF,
	parameter int VALUE_BITS = dngr_pkg::VALUE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire dngr_pkg::dngr_in_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output dngr_pkg::dngr_out_t     rsp,
	input  wire logic               cfg_wen,
	input  wire logic               cfg_wdata
);

	dngr_pkg::dngr_cmd_t cmd;
	dngr_pkg::dngr_sts_t sts;

	// controller
	dngr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath
	dngr_dp #(
		.ROW_PITCH  (ROW_PITCH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk (clk),
		.req (req),
		.cmd (cmd),
		.sts (sts),
		.rsp (rsp)
	);

	// a held item is never overwritten
	`DNGR_ASSERT_NOW(a_no_overwrite, cmd.emit, !rsp_valid || rsp_ready)
	// busy straight after an item is taken
	`DNGR_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	// final row only at the end of the last digit glyph
	`DNGR_ASSERT_NOW(a_last_at_end, cmd.last, cmd.glyph_end && sts.done && cmd.emit)

endmodule

`default_nettype wire

>>> sv/dngr_ctrl.sv
// Controller: sequences digit steps and glyph rows, owns handshakes.
`default_nettype none

module dngr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	input  wire logic                cfg_wen,
	input  wire logic                cfg_wdata,
	output dngr_pkg::dngr_cmd_t      cmd,
	input  wire dngr_pkg::dngr_sts_t sts
);

	dngr_pkg::dngr_state_t state_q, state_d;
	logic       pad_en_q;
	logic [1:0] pad_cnt_q;
	logic [2:0] row_q;
	logic       rsp_valid_q;
	logic       slot_free;

	// result slot empties or is taken this cycle
	assign slot_free = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dngr_pkg::ST_IDLE: begin
				if (req_valid) state_d = dngr_pkg::ST_DIGIT;
			end
			dngr_pkg::ST_DIGIT: begin
				state_d = dngr_pkg::ST_ROWS;
			end
			dngr_pkg::ST_ROWS: begin
				if (slot_free && row_q == dngr_pkg::LAST_ROW) begin
					state_d = sts.done ? dngr_pkg::ST_IDLE : dngr_pkg::ST_DIGIT;
				end
			end
			default: state_d = dngr_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.row       = row_q;
		req_ready     = 1'b0;
		unique case (state_q)
			dngr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			dngr_pkg::ST_DIGIT: begin
				cmd.pad_glyph = pad_cnt_q != 2'd0;
				cmd.extract   = pad_cnt_q == 2'd0;
			end
			dngr_pkg::ST_ROWS: begin
				cmd.emit      = slot_free;
				cmd.glyph_end = slot_free && row_q == dngr_pkg::LAST_ROW;
				cmd.last      = slot_free && row_q == dngr_pkg::LAST_ROW && sts.done;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	// state, counters, config bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dngr_pkg::ST_IDLE;
			pad_en_q    <= 1'b0;
			pad_cnt_q   <= 2'd0;
			row_q       <= 3'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) pad_en_q <= cfg_wdata;
			if (cmd.load) begin
				pad_cnt_q <= pad_en_q ? 2'd2 : 2'd0;
			end else if (cmd.pad_glyph) begin
				pad_cnt_q <= pad_cnt_q - 2'd1;
			end
			if (cmd.pad_glyph || cmd.extract) begin
				row_q <= 3'd0;
			end else if (cmd.emit) begin
				row_q <= row_q + 3'd1;
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/dngr_dp.sv
// Datapath: digit extraction, glyph position and result register.
`default_nettype none

module dngr_dp #(
	parameter int ROW_PITCH  = dngr_pkg::ROW_PITCH_DEF,
	parameter int VALUE_BITS = dngr_pkg::VALUE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire dngr_pkg::dngr_in_t  req,
	input  wire dngr_pkg::dngr_cmd_t cmd,
	output dngr_pkg::dngr_sts_t      sts,
	output dngr_pkg::dngr_out_t      rsp
);

	// the value field is 16 bits wide, so at most 16 bits take part
	localparam int VW     = (VALUE_BITS < dngr_pkg::VALUE_W) ? VALUE_BITS : dngr_pkg::VALUE_W;
	localparam int PW     = VW + 17;
	localparam int AW     = dngr_pkg::ADDR_W;
	localparam logic [16:0] RECIP = 17'd52429;   // 2^19 / 10 rounded up, exact below 81920

	logic [VW-1:0]   val_q;
	logic [AW-1:0]   pos_q;
	logic [7:0]      colour_q;
	logic [3:0]      digit_q;
	logic            done_q;
	dngr_pkg::dngr_out_t rsp_q;

	logic [AW-1:0]   base;
	logic [PW-1:0]   prod;
	logic [VW-1:0]   quot;
	logic [VW-1:0]   quot_x10;
	logic [3:0]      rem;
	logic            narrow;
	logic [AW-1:0]   row_addr;
	dngr_pkg::dngr_out_t row_item;

	// base address of the rightmost digit
	assign base = AW'(AW'(req.y_pos) * AW'(ROW_PITCH)) + AW'(req.x_pos);

	// divide by ten via reciprocal
	assign prod     = PW'(val_q) * PW'(RECIP);
	assign quot     = VW'(prod >> 19);
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem      = 4'(val_q - quot_x10);

	// row of the current glyph
	assign narrow   = dngr_pkg::is_narrow(digit_q);
	assign row_addr = pos_q - AW'(!narrow) + AW'(AW'(cmd.row) * AW'(ROW_PITCH));

	always_comb begin
		logic [1:0] shade [dngr_pkg::COLS];
		for (int c = 0; c < dngr_pkg::COLS; c++) begin
			shade[c] = (c == dngr_pkg::COLS - 1 && narrow) ? 2'd0 :
				dngr_pkg::glyph_shade(digit_q, cmd.row, c);
		end
		row_item.row_address = row_addr;
		row_item.pixel_a     = dngr_pkg::shade_pixel(shade[0], colour_q);
		row_item.pixel_b     = dngr_pkg::shade_pixel(shade[1], colour_q);
		row_item.pixel_c     = dngr_pkg::shade_pixel(shade[2], colour_q);
		row_item.pixel_d     = dngr_pkg::shade_pixel(shade[3], colour_q);
		row_item.pixel_e     = dngr_pkg::shade_pixel(shade[4], colour_q);
		for (int c = 0; c < dngr_pkg::COLS; c++) begin
			row_item.write_mask[c] = shade[c] != 2'd0;
		end
		row_item.last_row = cmd.last;
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q    <= req.value[VW-1:0];
			pos_q    <= base;
			colour_q <= req.colour;
		end else if (cmd.extract) begin
			val_q <= quot;
		end else if (cmd.glyph_end) begin
			pos_q <= pos_q - (narrow ? AW'(5) : AW'(6));
		end
		if (cmd.pad_glyph) begin
			digit_q <= 4'd0;
		end else if (cmd.extract) begin
			digit_q <= rem;
		end
		if (cmd.emit) rsp_q <= row_item;
	end

	// last digit flag, cleared per item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			done_q <= 1'b0;
		end else if (cmd.extract) begin
			done_q <= quot == '0;
		end
	end

	assign sts.done = done_q;
	assign rsp      = rsp_q;

endmodule

`default_nettype wire

>>> verif/decimal_number_glyph_renderer_checker.sv
// Checker for the glyph renderer: predicts every row write of each number and compares.
`timescale 1ns / 1ps

module decimal_number_glyph_renderer_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  dngr_pkg::dngr_in_t            req,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  dngr_pkg::dngr_out_t           rsp,
	input  logic                          cfg_wen,
	input  logic                          cfg_wdata,
	input  logic                          final_check,
	output int                            fail_count,
	output int                            outstanding,
	output int                            rows_checked
);

	localparam int ROW_STRIDE  = 128;

	// Shades per glyph row, one hex digit per column, leftmost column first
	localparam logic [19:0] GLYPH_ART [10][7] = '{
		'{20'h03320, 20'h30030, 20'h30031, 20'h30031, 20'h30031, 20'h32230, 20'h03310},
		'{20'h00220, 20'h01320, 20'h12220, 20'h00220, 20'h00220, 20'h00220, 20'h00220},
		'{20'h01321, 20'h13112, 20'h00012, 20'h00131, 20'h01320, 20'h02200, 20'h13332},
		'{20'h03300, 20'h32230, 20'h00230, 20'h03320, 20'h00230, 20'h31230, 20'h03300},
		'{20'h00030, 20'h00231, 20'h00331, 20'h02231, 20'h03031, 20'h23333, 20'h00030},
		'{20'h03330, 20'h23000, 20'h23320, 20'h00131, 20'h00032, 20'h32031, 20'h03320},
		'{20'h02320, 20'h13030, 20'h23000, 20'h23330, 20'h23032, 20'h13032, 20'h02330},
		'{20'h23332, 20'h00031, 20'h00130, 20'h00320, 20'h01300, 20'h02300, 20'h02300},
		'{20'h02330, 20'h13023, 20'h13023, 20'h02330, 20'h13023, 20'h13023, 20'h02330},
		'{20'h03300, 20'h30230, 20'h30230, 20'h03330, 20'h00130, 20'h31230, 20'h03300}
	};

	// Narrow glyphs (4 columns, step 5): digits one, three and nine
	localparam logic [9:0] NARROW_SET = 10'b10_0000_1010;

	dngr_pkg::dngr_out_t expected_rows [$];
	logic      pad_on = 1'b0;
	int        errors = 0;
	int        rows_seen = 0;
	bit        leftovers_flagged = 1'b0;

	task automatic log_fault(input string msg);
		$display("checker: %s", msg);
		errors++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			log_fault($sformatf("row %0d: %s is %0d, expected %0d", rows_seen, name, got, want));
	endtask

	// Queues the seven rows of one glyph; returns the base of the next glyph to the left
	function automatic logic [13:0] add_glyph(input int unsigned digit, input logic [13:0] base,
		input logic [7:0] colour, input bit closing);
		dngr_pkg::dngr_out_t row;
		logic [19:0]     art;
		logic [1:0]      shade;
		logic [4:0][9:0] pix;
		logic [13:0]     left;
		bit              narrow;
		int              r, c;
		narrow = NARROW_SET[digit];
		left = narrow ? base : base - 14'd1;
		for (r = 0; r < 7; r++) begin
			art = GLYPH_ART[digit][r];
			row = '0;
			row.row_address = left + 14'(r * ROW_STRIDE);
			for (c = 0; c < 5; c++) begin
				shade = (narrow && c == 4) ? 2'd0 : art[16 - 4*c +: 2];
				pix[c] = 10'(shade) * 10'(colour);
				row.write_mask[c] = (shade != 2'd0);
			end
			row.pixel_a = pix[0];
			row.pixel_b = pix[1];
			row.pixel_c = pix[2];
			row.pixel_d = pix[3];
			row.pixel_e = pix[4];
			row.last_row = closing && (r == 6);
			expected_rows.push_back(row);
		end
		return narrow ? base - 14'd5 : base - 14'd6;
	endfunction

	// Digits least significant first, optional zero pads drawn at the base beforehand
	function automatic void render_number(input dngr_pkg::dngr_in_t it, input logic pad);
		int unsigned digs [$];
		int unsigned v;
		logic [13:0] base;
		int          i;
		v = it.value;
		do begin
			digs.push_back(v % 10);
			v = v / 10;
		end while (v != 0);
		base = 14'(int'(it.y_pos) * ROW_STRIDE + int'(it.x_pos));
		if (pad) begin
			base = add_glyph(0, base, it.colour, 1'b0);
			base = add_glyph(0, base, it.colour, 1'b0);
		end
		for (i = 0; i < digs.size(); i++)
			base = add_glyph(digs[i], base, it.colour, i == digs.size() - 1);
	endfunction

	task automatic check_row(input dngr_pkg::dngr_out_t got);
		dngr_pkg::dngr_out_t want;
		rows_seen++;
		if (expected_rows.size() == 0) begin
			log_fault($sformatf("row %0d at address %0d arrived with nothing expected",
				rows_seen, got.row_address));
			return;
		end
		want = expected_rows.pop_front();
		compare_field("row_address", got.row_address, want.row_address);
		compare_field("pixel_a", got.pixel_a, want.pixel_a);
		compare_field("pixel_b", got.pixel_b, want.pixel_b);
		compare_field("pixel_c", got.pixel_c, want.pixel_c);
		compare_field("pixel_d", got.pixel_d, want.pixel_d);
		compare_field("pixel_e", got.pixel_e, want.pixel_e);
		compare_field("write_mask", got.write_mask, want.write_mask);
		compare_field("last_row", got.last_row, want.last_row);
	endtask

	// Sample both channels and the register port at each edge
	always @(posedge clk) begin
		if (!arst_n) begin
			pad_on <= 1'b0;
			expected_rows.delete();
		end else begin
			if (cfg_wen)
				pad_on <= cfg_wdata;
			if (rsp_valid && rsp_ready)
				check_row(rsp);
			if (req_valid && req_ready)
				render_number(req, pad_on);
			if (final_check && !leftovers_flagged && expected_rows.size() != 0) begin
				log_fault($sformatf("%0d expected rows never arrived", expected_rows.size()));
				leftovers_flagged = 1'b1;
			end
		end
		outstanding  <= expected_rows.size();
		fail_count   <= errors;
		rows_checked <= rows_seen;
	end

endmodule

>>> verif/decimal_number_glyph_renderer_test.sv
// Top of the glyph renderer testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module decimal_number_glyph_renderer_test;

	localparam int RANDOM_PER_PHASE = 150;
	localparam int HOLD_CYCLES      = 300;
	localparam int STALL_LIMIT      = 4000;
	localparam int DRAIN_CYCLES     = 64;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	dngr_pkg::dngr_in_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	dngr_pkg::dngr_out_t rsp;
	logic      cfg_wen;
	logic      cfg_wdata;
	logic      final_check;

	int fail_count;
	int outstanding;
	int rows_checked;

	bit hold_request = 1'b0;
	bit steady = 1'b0;
	int holds_done = 0;
	int items_sent = 0;
	int directed_sent = 0;
	int pad_writes = 0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	decimal_number_glyph_renderer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	decimal_number_glyph_renderer_checker glyph_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.final_check  (final_check),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.rows_checked (rows_checked)
	);

	// Idle cycles before an item; at least a third of the draws give none
	function automatic int pick_gap();
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	// Mostly full-range fields, with extremes and short numbers mixed in
	function automatic dngr_pkg::dngr_in_t random_item();
		dngr_pkg::dngr_in_t it;
		case ($urandom_range(0, 5))
			0: it.value = 16'($urandom_range(0, 9));
			1: it.value = 16'($urandom_range(10, 999));
			2: it.value = 16'hFFFF - 16'($urandom_range(0, 15));
			default: it.value = 16'($urandom);
		endcase
		it.x_pos = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 7'd127 : 7'd0)
			: 7'($urandom);
		it.y_pos = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 7'd127 : 7'd0)
			: 7'($urandom);
		it.colour = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
			: 8'($urandom);
		return it;
	endfunction

	// Offer one item and hold it until it is taken
	task automatic offer_item(input dngr_pkg::dngr_in_t it, input bit eager);
		int gap;
		gap = (eager || steady) ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic offer_fields(input int unsigned value, input int unsigned x,
		input int unsigned y, input int unsigned colour);
		dngr_pkg::dngr_in_t it;
		it.value  = 16'(value);
		it.x_pos  = 7'(x);
		it.y_pos  = 7'(y);
		it.colour = 8'(colour);
		offer_item(it, 1'b0);
		directed_sent++;
	endtask

	// Stop offering and wait for every expected row before touching the register
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pad(input logic pad);
		cfg_wen <= 1'b1;
		cfg_wdata <= pad;
		@(posedge clk);
		cfg_wen <= 1'b0;
		pad_writes++;
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int gap;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request <= 1'b0;
				holds_done++;
			end
			gap = steady ? 0 : pick_gap();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	// Watchdog: too long with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", quiet_cycles);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int n;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_wen <= 1'b0;
		cfg_wdata <= 1'b0;
		final_check <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, no padding: zero, maximum, narrow digits, wrap below address 0
		write_pad(1'b0);
		offer_fields(0, 64, 64, 1);
		offer_fields(65535, 127, 127, 255);
		offer_fields(1, 0, 0, 200);
		offer_fields(3, 5, 10, 255);
		offer_fields(9, 2, 0, 3);
		offer_fields(12345, 0, 0, 255);
		offer_fields(67890, 100, 50, 7);
		offer_fields(13579, 60, 20, 0);
		offer_fields(24680, 127, 0, 128);
		offer_fields(10, 0, 127, 85);
		offer_fields(40000, 50, 127, 170);
		offer_fields(7, 127, 127, 1);
		offer_fields(8, 0, 64, 254);
		offer_fields(6, 30, 30, 255);
		wait_idle();

		// Directed with two trailing zero pads
		write_pad(1'b1);
		offer_fields(0, 0, 0, 255);
		offer_fields(65535, 127, 127, 255);
		offer_fields(5, 64, 3, 9);
		offer_fields(1, 1, 0, 0);
		offer_fields(4096, 20, 100, 255);
		offer_fields(2, 127, 0, 77);
		wait_idle();

		// Random, no padding
		write_pad(1'b0);
		for (n = 0; n < RANDOM_PER_PHASE; n++)
			offer_item(random_item(), 1'b0);
		wait_idle();

		// Random, padded; the sink holds off while the source keeps offering
		write_pad(1'b1);
		for (n = 0; n < RANDOM_PER_PHASE; n++) begin
			if (n == 40)
				hold_request <= 1'b1;
			offer_item(random_item(), n >= 40 && n < 70);
		end
		wait_idle();

		// Random, no padding, opening with a stretch free of idling
		write_pad(1'b0);
		steady <= 1'b1;
		for (n = 0; n < RANDOM_PER_PHASE; n++) begin
			if (n == 50)
				steady <= 1'b0;
			offer_item(random_item(), 1'b0);
		end

		// Drain, then look for leftovers
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		final_check <= 1'b1;
		repeat (2) @(posedge clk);

		$display("covered %0d numbers (%0d directed) drawn as %0d glyph rows",
			items_sent, directed_sent, rows_checked);
		$display("padding written %0d times, %0d long output hold-offs, bursts with no idling",
			pad_writes, holds_done);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
